@@ hw/rtl/block_run_length_encoder_macros.svh @@
// assertion macros for the block run-length encoder checker
// no dependencies; included by files that carry concurrent assertions
`ifndef BLOCK_RUN_LENGTH_ENCODER_MACROS_SVH
`define BLOCK_RUN_LENGTH_ENCODER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rle_pkg.sv @@
// shared constants and types for the block run-length encoder
// no dependencies; imported by all rtl modules of the block
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam int MAX_BLOCK_DEF = 16;
  localparam int IDX_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 8;

  localparam logic [CNT_W-1:0] COUNT_CAP = 8'd255;
  localparam logic [IDX_W-1:0] LEN_RESET = 5'd1;

  // control from the sequencer to the block stores
  typedef struct packed {
    logic              new_we;
    logic [IDX_W-1:0]  new_waddr;
    logic [BYTE_W-1:0] new_wdata;
    logic              run_we;
    logic [IDX_W-1:0]  run_waddr;
    logic [BYTE_W-1:0] run_wdata;
    logic [IDX_W-1:0]  rd_addr;
  } store_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/rle_store.sv @@
// block stores: the block being filled and the block of the current run
// depends on rle_pkg; one write port per store, shared registered read address
`timescale 1ns / 1ps
`default_nettype none

module rle_store #(
  parameter int MAX_BLOCK = rle_pkg::MAX_BLOCK_DEF
) (
  input  wire                      clk,
  input  rle_pkg::store_ctl_t      ctl,
  output logic [rle_pkg::BYTE_W-1:0] run_q,
  output logic [rle_pkg::BYTE_W-1:0] new_q
);
  import rle_pkg::*;

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  logic [BYTE_W-1:0] new_mem [MAX_BLOCK];
  logic [BYTE_W-1:0] run_mem [MAX_BLOCK];

  always_ff @(posedge clk) begin
    if (ctl.new_we) begin
      new_mem[ctl.new_waddr[AW-1:0]] <= ctl.new_wdata;
    end
    new_q <= new_mem[ctl.rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.run_we) begin
      run_mem[ctl.run_waddr[AW-1:0]] <= ctl.run_wdata;
    end
    run_q <= run_mem[ctl.rd_addr[AW-1:0]];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rle_seq.sv @@
// sequencer of the block run-length encoder: fill, compare, copy and emit passes
// depends on rle_pkg; drives rle_store and owns the output register
`timescale 1ns / 1ps
`default_nettype none

module rle_seq #(
  parameter int MAX_BLOCK = rle_pkg::MAX_BLOCK_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  [rle_pkg::IDX_W-1:0]   blk_len,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_action,
  input  wire  [rle_pkg::BYTE_W-1:0]  in_byte,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [rle_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output rle_pkg::store_ctl_t         ctl,
  input  wire  [rle_pkg::BYTE_W-1:0]  run_q,
  input  wire  [rle_pkg::BYTE_W-1:0]  new_q
);
  import rle_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_WK    = 2'd3;

  localparam logic [1:0] OP_CMP  = 2'd0;
  localparam logic [1:0] OP_COPY = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;
  localparam logic [1:0] OP_PART = 2'd3;

  localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_BLOCK);

  logic [1:0]        state;
  logic [1:0]        op;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  part_n;
  logic [CNT_W-1:0]  count;
  logic              have_run;
  logic              mism;
  logic              copy_after;
  logic              part_after;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [IDX_W-1:0]  fill_inc;
  logic              last_idx;
  logic              mism_next;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;

  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && in_ready;
    out_free  = !out_valid || out_ready;
    // the output register takes a count byte or a block byte this cycle
    out_load  = out_free && ((state == ST_COUNT) ||
                ((state == ST_WK) && (op != OP_CMP) && (op != OP_COPY)));
    fill_inc  = fill + 1'b1;
    last_idx  = (idx == blk_len - 1'b1);
    mism_next = mism || (run_q != new_q);

    // zero padding beyond the gathered bytes of a partial block
    if (op == OP_PART) begin
      emit_byte = (idx < part_n) ? new_q : '0;
    end else begin
      emit_byte = run_q;
    end
    emit_last = last_idx && ((op == OP_PART) || !part_after);

    ctl.new_we    = accept && !in_action && (fill < MAX_LEN);
    ctl.new_waddr = fill;
    ctl.new_wdata = in_byte;
    ctl.run_we    = (state == ST_WK) &&
                    ((op == OP_COPY) || ((op == OP_RUN) && copy_after && out_free));
    ctl.run_waddr = idx;
    ctl.run_wdata = new_q;
    ctl.rd_addr   = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      count     <= '0;
      have_run  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            idx <= '0;
            if (!in_action) begin
              if (fill_inc >= blk_len) begin
                fill  <= '0;
                mism  <= 1'b0;
                op    <= have_run ? OP_CMP : OP_COPY;
                state <= ST_RD;
              end else begin
                fill <= fill_inc;
              end
            end else begin
              fill       <= '0;
              part_n     <= (fill < blk_len) ? fill : blk_len;
              part_after <= (fill != '0);
              copy_after <= 1'b0;
              if (have_run) begin
                op    <= OP_RUN;
                state <= ST_COUNT;
              end else if (fill != '0) begin
                op    <= OP_PART;
                state <= ST_COUNT;
              end
            end
          end
        end
        ST_COUNT: begin
          if (out_free) begin
            out_byte  <= (op == OP_PART) ? CNT_W'(1) : count;
            out_last  <= 1'b0;
            idx       <= '0;
            state     <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_WK;
        end
        ST_WK: begin
          case (op)
            OP_CMP: begin
              mism <= mism_next;
              if (last_idx) begin
                if (!mism_next && (count != COUNT_CAP)) begin
                  count <= count + 1'b1;
                  state <= ST_IDLE;
                end else begin
                  op         <= OP_RUN;
                  copy_after <= 1'b1;
                  part_after <= 1'b0;
                  state      <= ST_COUNT;
                end
              end else begin
                idx   <= idx + 1'b1;
                state <= ST_RD;
              end
            end
            OP_COPY: begin
              if (last_idx) begin
                count    <= CNT_W'(1);
                have_run <= 1'b1;
                state    <= ST_IDLE;
              end else begin
                idx   <= idx + 1'b1;
                state <= ST_RD;
              end
            end
            default: begin
              if (out_free) begin
                out_byte  <= emit_byte;
                out_last  <= emit_last;
                if (last_idx) begin
                  if ((op == OP_RUN) && copy_after) begin
                    count <= CNT_W'(1);
                    state <= ST_IDLE;
                  end else if ((op == OP_RUN) && part_after) begin
                    op    <= OP_PART;
                    state <= ST_COUNT;
                  end else begin
                    // end of a flush
                    count    <= '0;
                    have_run <= 1'b0;
                    state    <= ST_IDLE;
                  end
                end else begin
                  idx   <= idx + 1'b1;
                  state <= ST_RD;
                end
              end
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/block_run_length_encoder.sv @@
// block run-length encoder, top level
// depends on rle_pkg, rle_store and rle_seq
//
// Input stream (s_axis): one byte per transfer in tdata, tuser = 1 flushes
// the pending run at end of stream (tdata is ignored then). Output stream
// (m_axis): encoded bytes, a count byte followed by the bytes of one block;
// tlast marks the final byte caused by one input transfer.
// block_length (cfg_wr_en / cfg_wr_data) sets the bytes per block, 0 acts
// as 1 and values above MAX_BLOCK act as MAX_BLOCK; write it only while idle.
// Passes: a byte that does not complete a block starts no pass. A completed
// block is compared one entry at a time (registered store read, then the
// shared byte compare). An emitted run sends the count byte, then each block
// byte with its own registered store read, and the store copy rides along with
// that pass; the first block of a run is copied one entry at a time by its own pass.
// The input is not ready while a pass is running; an output stall holds the
// output register and the pass waits on it.
// Reset clears the run, the fill count and the output valid flag and sets
// block_length to 1; the block stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module block_run_length_encoder #(
  parameter int MAX_BLOCK = rle_pkg::MAX_BLOCK_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_wr_en,
  input  wire  [rle_pkg::IDX_W-1:0]  cfg_wr_data,    // block_length
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [rle_pkg::BYTE_W-1:0] s_axis_tdata,   // data_byte
  input  wire                        s_axis_tuser,   // action
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [rle_pkg::BYTE_W-1:0] m_axis_tdata,   // out_byte
  output logic                       m_axis_tlast    // last
);
  import rle_pkg::*;

  localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_BLOCK);

  logic [IDX_W-1:0]  block_length;
  logic [IDX_W-1:0]  eff_len;
  store_ctl_t        ctl;
  logic [BYTE_W-1:0] run_q;
  logic [BYTE_W-1:0] new_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= LEN_RESET;
    end else if (cfg_wr_en) begin
      block_length <= cfg_wr_data;
    end
  end

  always_comb begin
    if (block_length == '0) begin
      eff_len = IDX_W'(1);
    end else if (block_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = block_length;
    end
  end

  rle_store #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_store (
    .clk  (clk),
    .ctl  (ctl),
    .run_q(run_q),
    .new_q(new_q)
  );

  rle_seq #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .blk_len  (eff_len),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_action(s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte (m_axis_tdata),
    .out_last (m_axis_tlast),
    .ctl      (ctl),
    .run_q    (run_q),
    .new_q    (new_q)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rle_checker.sv @@
// port-level checks for the block run-length encoder, bound to the top level
// depends on rle_pkg and block_run_length_encoder_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "block_run_length_encoder_macros.svh"

module rle_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        s_axis_tready,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [rle_pkg::BYTE_W-1:0]  m_axis_tdata,
  input wire                        m_axis_tlast
);
  import rle_pkg::*;

  // output register is empty right after reset
  `RLE_ASSERT_SAME(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid, "output valid after reset")

  // a stalled transfer keeps its byte and end mark
  `RLE_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

  // while an encoded sequence is still going out, no new input is taken
  `RLE_ASSERT_SAME(a_busy_not_ready, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready in mid sequence")

endmodule

bind block_run_length_encoder rle_checker u_rle_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
